@@ sv/rmaa_pkg.sv @@
// ----------------------------------------------------------------------------
// rmaa_pkg: shared types and constants for the axis-angle converter
// Branch codes, the queued request format and the CORDIC arc table.
// ----------------------------------------------------------------------------
package rmaa_pkg;

	localparam int FIFO_DEPTH_DEF = 4;
	localparam int ONE_Q14        = 16384;
	localparam int SINE_RATIO     = 2000;
	localparam int CORDIC_STEPS   = 20;
	localparam logic [21:0] PI_Q20 = 22'd3294199;

	typedef enum logic [1:0] {
		BR_W = 2'd0,
		BR_X = 2'd1,
		BR_Y = 2'd2,
		BR_Z = 2'd3
	} branch_t;

	typedef logic signed [17:0] dval_t;

	typedef struct packed {
		logic [16:0] t;
		branch_t     br;
		dval_t [3:0] d;
	} front_item_t;

	// atan(2^-i) in Q20 radians
	function automatic logic [19:0] arc_q20(input int idx);
		logic [19:0] a;
		unique case (idx)
			0:  a = 20'd823550;
			1:  a = 20'd486170;
			2:  a = 20'd256879;
			3:  a = 20'd130396;
			4:  a = 20'd65451;
			5:  a = 20'd32757;
			6:  a = 20'd16383;
			7:  a = 20'd8192;
			8:  a = 20'd4096;
			9:  a = 20'd2048;
			10: a = 20'd1024;
			11: a = 20'd512;
			12: a = 20'd256;
			13: a = 20'd128;
			14: a = 20'd64;
			15: a = 20'd32;
			16: a = 20'd16;
			17: a = 20'd8;
			18: a = 20'd4;
			19: a = 20'd2;
			default: a = 20'd0;
		endcase
		return a;
	endfunction

endpackage

@@ sv/rmaa_front.sv @@
// ----------------------------------------------------------------------------
// rmaa_front: request intake and branch classification
// Forms the four trace sums, picks the branch and the numerators.
// ----------------------------------------------------------------------------
module rmaa_front import rmaa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [143:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output front_item_t  out_item
);

	logic signed [15:0] a00, a10, a20, a01, a11, a21, a02, a12, a22;
	logic signed [18:0] s0, s1, s2, s3, t_sel;
	branch_t            br;
	dval_t [3:0]        d;
	logic               valid_q;
	front_item_t        item_q;

	assign a00 = in_data[15:0];
	assign a10 = in_data[31:16];
	assign a20 = in_data[47:32];
	assign a01 = in_data[63:48];
	assign a11 = in_data[79:64];
	assign a21 = in_data[95:80];
	assign a02 = in_data[111:96];
	assign a12 = in_data[127:112];
	assign a22 = in_data[143:128];

	always_comb begin
		s0 = 19'(ONE_Q14) + 19'(a00) + 19'(a11) + 19'(a22);
		s1 = 19'(ONE_Q14) + 19'(a00) - 19'(a11) - 19'(a22);
		s2 = 19'(ONE_Q14) + 19'(a11) - 19'(a00) - 19'(a22);
		s3 = 19'(ONE_Q14) + 19'(a22) - 19'(a00) - 19'(a11);
		// ties keep the earlier branch
		t_sel = s0;
		br    = BR_W;
		if (s1 > t_sel) begin
			t_sel = s1;
			br    = BR_X;
		end
		if (s2 > t_sel) begin
			t_sel = s2;
			br    = BR_Y;
		end
		if (s3 > t_sel) begin
			t_sel = s3;
			br    = BR_Z;
		end
		unique case (br)
			BR_W: begin
				d[0] = 18'(a12) - 18'(a21);
				d[1] = 18'(a20) - 18'(a02);
				d[2] = 18'(a01) - 18'(a10);
				d[3] = '0;
			end
			BR_X: begin
				d[0] = '0;
				d[1] = 18'(a01) + 18'(a10);
				d[2] = 18'(a20) + 18'(a02);
				d[3] = 18'(a12) - 18'(a21);
			end
			BR_Y: begin
				d[0] = 18'(a01) + 18'(a10);
				d[1] = '0;
				d[2] = 18'(a12) + 18'(a21);
				d[3] = 18'(a20) - 18'(a02);
			end
			default: begin
				d[0] = 18'(a20) + 18'(a02);
				d[1] = 18'(a12) + 18'(a21);
				d[2] = '0;
				d[3] = 18'(a01) - 18'(a10);
			end
		endcase
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q.t  <= t_sel[18] ? 17'd0 : t_sel[16:0];
			item_q.br <= br;
			item_q.d  <= d;
		end
	end

endmodule

@@ sv/rmaa_fifo.sv @@
// ----------------------------------------------------------------------------
// rmaa_fifo: short request queue between front and back
// Register-based ring buffer with a fill count.
// ----------------------------------------------------------------------------
module rmaa_fifo import rmaa_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  front_item_t in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output front_item_t out_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	front_item_t    mem_q [0:DEPTH-1];
	logic [AW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  count_q;
	logic           push, pop;

	assign in_ready  = count_q != CW'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count did not drop on pop");

endmodule

@@ sv/rmaa_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmaa_sqrt: pipelined rounded integer square root
// One root bit per stage, then a round-to-nearest stage; several lanes.
// ----------------------------------------------------------------------------
module rmaa_sqrt #(
	parameter int LANES = 1,
	parameter int W     = 36,
	parameter int PW    = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic [LANES*W-1:0]       in_rad,
	input  logic [PW-1:0]            in_pay,
	output logic                     out_valid,
	output logic [LANES*(W/2+1)-1:0] out_root,
	output logic [PW-1:0]            out_pay
);

	localparam int R = W / 2;

	logic [R:0]    vld_q;
	logic          vld_out_q;
	logic [W-1:0]  rem_q  [0:R][0:LANES-1];
	logic [R-1:0]  rt_q   [0:R][0:LANES-1];
	logic [R:0]    root_q [0:LANES-1];
	logic [PW-1:0] pay_q  [0:R];
	logic [PW-1:0] pay_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_out_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[R-1:0], in_valid};
			vld_out_q <= vld_q[R];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q[0] <= in_pay;
			for (int k = 1; k <= R; k++) begin
				pay_q[k] <= pay_q[k-1];
			end
			pay_out_q <= pay_q[R];
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[0][l] <= in_rad[l*W +: W];
				rt_q[0][l]  <= '0;
				// round up when the remainder exceeds the root
				root_q[l] <= (rem_q[R][l] > W'(rt_q[R][l])) ?
					(R+1)'(rt_q[R][l]) + 1'b1 : (R+1)'(rt_q[R][l]);
			end
		end

		for (genvar j = 1; j <= R; j++) begin : g_stage
			localparam int B = R - j;
			logic [W:0] trial, rem_ext;
			logic       take;

			assign rem_ext = {1'b0, rem_q[j-1][l]};
			assign trial   = ((W+1)'(rt_q[j-1][l]) << (B + 1)) + ((W+1)'(1) << (2 * B));
			assign take    = rem_ext >= trial;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q[j][l] <= take ? W'(rem_ext - trial) : rem_q[j-1][l];
					rt_q[j][l]  <= take ? (rt_q[j-1][l] | (R'(1) << B)) : rt_q[j-1][l];
				end
			end
		end

		assign out_root[l*(R+1) +: R+1] = root_q[l];
	end

	assign out_valid = vld_out_q;
	assign out_pay   = pay_out_q;

endmodule

@@ sv/rmaa_div.sv @@
// ----------------------------------------------------------------------------
// rmaa_div: pipelined restoring divider
// One quotient bit per stage; lanes share one divisor.
// ----------------------------------------------------------------------------
module rmaa_div #(
	parameter int LANES = 1,
	parameter int NW    = 36,
	parameter int DW    = 19,
	parameter int QW    = 19,
	parameter int PW    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [LANES*NW-1:0] in_num,
	input  logic [DW-1:0]       in_den,
	input  logic [PW-1:0]       in_pay,
	output logic                out_valid,
	output logic [LANES*QW-1:0] out_quot,
	output logic [PW-1:0]       out_pay
);

	localparam int CW = NW + DW;

	logic [QW:0]   vld_q;
	logic [NW-1:0] rem_q [0:QW][0:LANES-1];
	logic [QW-1:0] quo_q [0:QW][0:LANES-1];
	logic [DW-1:0] den_q [0:QW];
	logic [PW-1:0] pay_q [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[QW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q[0] <= in_pay;
			den_q[0] <= in_den;
			for (int k = 1; k <= QW; k++) begin
				pay_q[k] <= pay_q[k-1];
				den_q[k] <= den_q[k-1];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[0][l] <= in_num[l*NW +: NW];
				quo_q[0][l] <= '0;
			end
		end

		for (genvar j = 1; j <= QW; j++) begin : g_stage
			localparam int B = QW - j;
			logic [CW-1:0] shifted, rem_ext;
			logic          take;

			assign rem_ext = CW'(rem_q[j-1][l]);
			assign shifted = CW'(den_q[j-1]) << B;
			assign take    = rem_ext >= shifted;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q[j][l] <= take ? NW'(rem_ext - shifted) : rem_q[j-1][l];
					quo_q[j][l] <= take ? (quo_q[j-1][l] | (QW'(1) << B)) : quo_q[j-1][l];
				end
			end
		end

		assign out_quot[l*QW +: QW] = quo_q[QW][l];
	end

	assign out_valid = vld_q[QW];
	assign out_pay   = pay_q[QW];

endmodule

@@ sv/rmaa_back.sv @@
// ----------------------------------------------------------------------------
// rmaa_back: quaternion, angle and axis datapath
// Root and divisions build the quaternion, then norms, CORDIC arc and the
// axis divisions; the whole pipe holds while the output register is full and out_ready is low.
// ----------------------------------------------------------------------------
module rmaa_back import rmaa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  front_item_t in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_axis_x,
	output logic [15:0] out_axis_y,
	output logic [15:0] out_axis_z,
	output logic [15:0] out_angle,
	output logic        out_degenerate
);

	localparam int GRW = 36;  // radicand of the large component
	localparam int GW  = 19;  // large component g
	localparam int NW1 = 36;
	localparam int QV  = 20;  // quaternion component, signed Q17
	localparam int SW  = 40;  // squared norms, Q34
	localparam int RW  = 21;  // norm roots
	localparam int XW  = 32;  // CORDIC x and y
	localparam int ZW  = 23;  // CORDIC angle accumulator
	localparam int NW2 = 34;
	localparam int QW2 = 16;

	typedef logic signed [QV-1:0] qval_t;

	typedef struct packed {
		branch_t     br;
		dval_t [3:0] d;
	} pay_g_t;

	typedef struct packed {
		branch_t       br;
		logic [3:0]    neg;
		logic [GW-1:0] g;
	} pay_d_t;

	typedef struct packed {
		qval_t [3:0] q;
	} pay_n_t;

	typedef struct packed {
		qval_t [2:0]    q;
		logic [RW-1:0]  dv;
		logic           flip;
		logic           deg;
	} pay_c_t;

	typedef struct packed {
		logic [15:0] angle;
		logic [2:0]  ovf;
		logic [2:0]  rneg;
		logic        deg;
	} pay_f_t;

	logic adv;
	logic out_valid_q;
	logic [15:0] ax_q, ay_q, az_q, ang_q;
	logic deg_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;

	// large component root
	logic [GRW-1:0]          g_rad;
	pay_g_t                  g_pay_in, g_pay;
	logic [$bits(pay_g_t)-1:0] g_pay_out;
	logic                    g_valid;
	logic [GW-1:0]           g_root;

	assign g_rad    = {1'b0, in_item.t, 18'd0};
	assign g_pay_in = '{br: in_item.br, d: in_item.d};
	assign g_pay    = pay_g_t'(g_pay_out);

	rmaa_sqrt #(.LANES(1), .W(GRW), .PW($bits(pay_g_t))) u_sqrt_g (
		.clk, .arst_n, .adv,
		.in_valid (in_valid),
		.in_rad   (g_rad),
		.in_pay   (g_pay_in),
		.out_valid(g_valid),
		.out_root (g_root),
		.out_pay  (g_pay_out)
	);

	// other components: round(d * 2^18 / g)
	logic [4*NW1-1:0]          num1;
	pay_d_t                    d_pay_in, d_pay;
	logic [$bits(pay_d_t)-1:0] d_pay_out;
	logic                      d_valid;
	logic [4*GW-1:0]           quot1;

	always_comb begin
		logic [17:0] dabs;
		for (int i = 0; i < 4; i++) begin
			dabs = g_pay.d[i][17] ? 18'(-g_pay.d[i]) : 18'(g_pay.d[i]);
			num1[i*NW1 +: NW1] = (NW1'(dabs) << 18) + NW1'(g_root >> 1);
			d_pay_in.neg[i] = g_pay.d[i][17];
		end
		d_pay_in.br = g_pay.br;
		d_pay_in.g  = g_root;
	end

	assign d_pay = pay_d_t'(d_pay_out);

	rmaa_div #(.LANES(4), .NW(NW1), .DW(GW), .QW(GW), .PW($bits(pay_d_t))) u_div_q (
		.clk, .arst_n, .adv,
		.in_valid (g_valid),
		.in_num   (num1),
		.in_den   (g_root),
		.in_pay   (d_pay_in),
		.out_valid(d_valid),
		.out_quot (quot1),
		.out_pay  (d_pay_out)
	);

	// quaternion, squares and sums
	qval_t [3:0]            q_s3, q_s4, q_s5;
	logic signed [SW-1:0]   sq_s4 [0:3];
	logic [SW-1:0]          n2_s5, v2_s5;
	logic                   v_s3, v_s4, v_s5;
	qval_t [3:0]            q_next;

	always_comb begin
		logic [QV-1:0] qmag;
		for (int i = 0; i < 4; i++) begin
			qmag = {1'b0, quot1[i*GW +: GW]};
			q_next[i] = d_pay.neg[i] ? qval_t'(-qmag) : qval_t'(qmag);
		end
		unique case (d_pay.br)
			BR_W: q_next[3] = qval_t'({1'b0, d_pay.g});
			BR_X: q_next[0] = qval_t'({1'b0, d_pay.g});
			BR_Y: q_next[1] = qval_t'({1'b0, d_pay.g});
			default: q_next[2] = qval_t'({1'b0, d_pay.g});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= d_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s3 <= q_next;
			q_s4 <= q_s3;
			for (int i = 0; i < 4; i++) begin
				sq_s4[i] <= $signed(q_s3[i]) * $signed(q_s3[i]);
			end
			q_s5  <= q_s4;
			v2_s5 <= SW'(sq_s4[0] + sq_s4[1] + sq_s4[2]);
			n2_s5 <= SW'(sq_s4[0] + sq_s4[1] + sq_s4[2] + sq_s4[3]);
		end
	end

	// norm and vector magnitude roots
	logic [2*SW-1:0]           n_rad;
	pay_n_t                    n_pay_in, n_pay;
	logic [$bits(pay_n_t)-1:0] n_pay_out;
	logic                      n_valid;
	logic [2*RW-1:0]           n_root;

	assign n_rad    = {v2_s5, n2_s5};
	assign n_pay_in = '{q: q_s5};
	assign n_pay    = pay_n_t'(n_pay_out);

	rmaa_sqrt #(.LANES(2), .W(SW), .PW($bits(pay_n_t))) u_sqrt_n (
		.clk, .arst_n, .adv,
		.in_valid (v_s5),
		.in_rad   (n_rad),
		.in_pay   (n_pay_in),
		.out_valid(n_valid),
		.out_root (n_root),
		.out_pay  (n_pay_out)
	);

	// CORDIC vectoring on (|q3|, vm)
	logic signed [XW-1:0] cx_q [0:CORDIC_STEPS];
	logic signed [XW-1:0] cy_q [0:CORDIC_STEPS];
	logic signed [ZW-1:0] cz_q [0:CORDIC_STEPS];
	pay_c_t               cp_q [0:CORDIC_STEPS];
	logic [CORDIC_STEPS:0] cv_q;

	logic [RW-1:0]        nrm, vm, dv_sel;
	logic                 small_sine;
	qval_t                q3;
	logic signed [QV-1:0] q3_abs;

	assign nrm        = n_root[RW-1:0];
	assign vm         = n_root[2*RW-1:RW];
	assign q3         = n_pay.q[3];
	assign q3_abs     = q3[QV-1] ? -q3 : q3;
	assign small_sine = (32'(vm) * 32'(SINE_RATIO)) < 32'(nrm);
	assign dv_sel     = small_sine ? nrm : vm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= '0;
		end else if (adv) begin
			cv_q <= {cv_q[CORDIC_STEPS-1:0], n_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_q[0]      <= XW'(q3_abs) <<< 8;
			cy_q[0]      <= XW'({vm, 8'd0});
			cz_q[0]      <= '0;
			cp_q[0].q    <= n_pay.q[2:0];
			cp_q[0].dv   <= (dv_sel == '0) ? RW'(1) : dv_sel;
			cp_q[0].flip <= q3[QV-1];
			cp_q[0].deg  <= nrm == '0;
			for (int k = 1; k <= CORDIC_STEPS; k++) begin
				cp_q[k] <= cp_q[k-1];
			end
		end
	end

	for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_cordic
		localparam int I = j - 1;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (cy_q[j-1] > 0) begin
					cx_q[j] <= cx_q[j-1] + (cy_q[j-1] >>> I);
					cy_q[j] <= cy_q[j-1] - (cx_q[j-1] >>> I);
					cz_q[j] <= cz_q[j-1] + ZW'(arc_q20(I));
				end else begin
					cx_q[j] <= cx_q[j-1] - (cy_q[j-1] >>> I);
					cy_q[j] <= cy_q[j-1] + (cx_q[j-1] >>> I);
					cz_q[j] <= cz_q[j-1] - ZW'(arc_q20(I));
				end
			end
		end
	end

	// angle finish and axis numerators
	pay_c_t                    cend;
	pay_f_t                    f_pay_in, f_pay;
	logic [$bits(pay_f_t)-1:0] f_pay_out;
	logic [3*NW2-1:0]          num2;
	logic                      f_valid;
	logic [3*QW2-1:0]          quot2;

	assign cend = cp_q[CORDIC_STEPS];

	always_comb begin
		logic signed [ZW-1:0] z;
		logic [21:0]          zc, arc;
		logic [16:0]          ang_full;
		logic [QV-1:0]        qa;
		logic [NW2-1:0]       nv;
		z   = cz_q[CORDIC_STEPS];
		zc  = z[ZW-1] ? 22'd0 : z[21:0];
		arc = cend.flip ? ((PI_Q20 >= zc) ? PI_Q20 - zc : 22'd0) : zc;
		ang_full = 17'(({1'b0, arc} + 23'd32) >> 6);
		f_pay_in.angle = ang_full[16] ? 16'hFFFF : ang_full[15:0];
		f_pay_in.deg   = cend.deg;
		for (int i = 0; i < 3; i++) begin
			qa = cend.q[i][QV-1] ? QV'(-cend.q[i]) : QV'(cend.q[i]);
			nv = (NW2'(qa) << 14) + NW2'(cend.dv >> 1);
			num2[i*NW2 +: NW2] = nv;
			// quotient too large for sixteen bits: saturate later
			f_pay_in.ovf[i]  = 38'(nv) >= (38'(cend.dv) << QW2);
			f_pay_in.rneg[i] = !cend.q[i][QV-1] && (cend.q[i] != '0);
		end
	end

	assign f_pay = pay_f_t'(f_pay_out);

	rmaa_div #(.LANES(3), .NW(NW2), .DW(RW), .QW(QW2), .PW($bits(pay_f_t))) u_div_axis (
		.clk, .arst_n, .adv,
		.in_valid (cv_q[CORDIC_STEPS]),
		.in_num   (num2),
		.in_den   (cend.dv),
		.in_pay   (f_pay_in),
		.out_valid(f_valid),
		.out_quot (quot2),
		.out_pay  (f_pay_out)
	);

	// saturate and hold in the output register
	logic [15:0] axis_res [0:2];

	always_comb begin
		logic [QW2-1:0] m;
		for (int i = 0; i < 3; i++) begin
			m = quot2[i*QW2 +: QW2];
			if (f_pay.deg) begin
				axis_res[i] = '0;
			end else if (f_pay.rneg[i]) begin
				axis_res[i] = (f_pay.ovf[i] || m > 16'd32768) ? 16'h8000 :
					16'(17'd0 - {1'b0, m});
			end else begin
				axis_res[i] = (f_pay.ovf[i] || m > 16'd32767) ? 16'h7FFF : m;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= f_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_q  <= axis_res[0];
			ay_q  <= axis_res[1];
			az_q  <= axis_res[2];
			ang_q <= f_pay.deg ? 16'd0 : f_pay.angle;
			deg_q <= f_pay.deg;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_axis_x     = ax_q;
	assign out_axis_y     = ay_q;
	assign out_axis_z     = az_q;
	assign out_angle      = ang_q;
	assign out_degenerate = deg_q;

endmodule

@@ sv/rotation_matrix_to_axis_angle_top.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_axis_angle_top: rotation matrix to axis and angle
// Throughput: one request per cycle; the back pipeline holds as a whole
// while its output register waits, the queue absorbs front-side requests.
// Reset: arst_n clears valid flags and queue pointers; data needs no reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_axis_angle_top import rmaa_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// r00, r10, r20, r01, r11, r21, r02, r12, r22 (16 bits each)
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// axis_x, axis_y, axis_z, angle (16 bits each)
	output logic [63:0]  m_axis_tdata,
	// degenerate
	output logic [0:0]   m_axis_tuser
);

	logic        f_valid, f_ready, b_valid, b_ready;
	front_item_t f_item, b_item;
	logic [15:0] ax, ay, az, ang;
	logic        deg;

	rmaa_front u_front (
		.clk, .arst_n,
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_item (f_item)
	);

	rmaa_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk, .arst_n,
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_item  (f_item),
		.out_valid(b_valid),
		.out_ready(b_ready),
		.out_item (b_item)
	);

	rmaa_back u_back (
		.clk, .arst_n,
		.in_valid      (b_valid),
		.in_ready      (b_ready),
		.in_item       (b_item),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_axis_x    (ax),
		.out_axis_y    (ay),
		.out_axis_z    (az),
		.out_angle     (ang),
		.out_degenerate(deg)
	);

	assign m_axis_tdata = {ang, az, ay, ax};
	assign m_axis_tuser = deg;

endmodule

@@ tb/rotation_matrix_to_axis_angle_top_test.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_axis_angle_top_test: self-checking bench for the converter
// Drives matrices over the input stream and predicts each axis-angle result
// in integer arithmetic, comparing every output request in order. Runs
// directed corner matrices, then random phases with sender gaps, receiver
// stalls, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module rotation_matrix_to_axis_angle_top_test import rmaa_pkg::*; ();

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	typedef struct packed {
		logic        degenerate;
		logic [63:0] axes_angle;
	} pose_t;

	pose_t pose_q[$];
	int    send_idle_pct;
	int    recv_stall_pct;
	int    hold_left;
	int    mismatches;
	int    results_seen;
	int    sent_count;

	rotation_matrix_to_axis_angle_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic longint unsigned sqrt_near(longint unsigned n);
		longint unsigned res, bitv, rem;
		res  = 0;
		bitv = 64'h1 << 62;
		rem  = n;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		if (rem > res) res++;
		return res;
	endfunction

	function automatic longint div_near(longint n, longint d);
		if (n >= 0) return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic logic [15:0] sat_q14(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// half angle by vectoring CORDIC, Q20 radians
	function automatic longint half_arc(longint xs, longint ys);
		longint x, y, z, dx, dy;
		x = (xs < 0 ? -xs : xs) * 256;
		y = ys * 256;
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(arc_q20(i));
			end else begin
				x -= dx; y += dy; z -= longint'(arc_q20(i));
			end
		end
		if (z < 0) z = 0;
		if (xs < 0) z = longint'(PI_Q20) - z;
		if (z < 0) z = 0;
		return z;
	endfunction

	function automatic pose_t predict_pose(logic [143:0] m);
		longint a[9];
		longint s[4], d[4], q[4];
		longint t, g, v2, n2, nrm, vm, dv, arc;
		branch_t br;
		pose_t p;
		for (int i = 0; i < 9; i++) a[i] = longint'($signed(m[16*i +: 16]));
		// a: 0=r00 1=r10 2=r20 3=r01 4=r11 5=r21 6=r02 7=r12 8=r22
		s[0] = ONE_Q14 + a[0] + a[4] + a[8];
		s[1] = ONE_Q14 + a[0] - a[4] - a[8];
		s[2] = ONE_Q14 + a[4] - a[0] - a[8];
		s[3] = ONE_Q14 + a[8] - a[0] - a[4];
		t  = s[0];
		br = BR_W;
		for (int i = 1; i < 4; i++)
			if (s[i] > t) begin
				t = s[i]; br = branch_t'(i);
			end
		if (t < 0) t = 0;
		g = longint'(sqrt_near(longint'(t) << 18));
		case (br)
			BR_W: begin
				d[0] = a[7] - a[5]; d[1] = a[2] - a[6]; d[2] = a[3] - a[1]; d[3] = 0;
			end
			BR_X: begin
				d[0] = 0; d[1] = a[3] + a[1]; d[2] = a[2] + a[6]; d[3] = a[7] - a[5];
			end
			BR_Y: begin
				d[0] = a[3] + a[1]; d[1] = 0; d[2] = a[7] + a[5]; d[3] = a[2] - a[6];
			end
			default: begin
				d[0] = a[2] + a[6]; d[1] = a[7] + a[5]; d[2] = 0; d[3] = a[3] - a[1];
			end
		endcase
		for (int i = 0; i < 4; i++) q[i] = (g == 0) ? 0 : div_near(d[i] * 262144, g);
		q[br == BR_W ? 3 : int'(br) - 1] = g;
		v2 = q[0] * q[0] + q[1] * q[1] + q[2] * q[2];
		n2 = v2 + q[3] * q[3];
		p = '0;
		if (n2 == 0) begin
			p.degenerate = 1'b1;
			return p;
		end
		nrm = longint'(sqrt_near(n2));
		vm  = longint'(sqrt_near(v2));
		arc = (half_arc(q[3], vm) + 32) >>> 6;
		if (arc > 65535) arc = 65535;
		dv = (SINE_RATIO * vm < nrm) ? nrm : vm;
		if (dv <= 0) dv = 1;
		for (int i = 0; i < 3; i++)
			p.axes_angle[16*i +: 16] = sat_q14(div_near(-q[i] * 16384, dv));
		p.axes_angle[63:48] = arc[15:0];
		return p;
	endfunction

	// offer one request after random gaps, hold until accepted
	task automatic send_matrix(logic [143:0] m);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= m;
		do @(posedge clk); while (!s_axis_tready);
		pose_q.insert(pose_q.size(), predict_pose(m));
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pose_q.size() != 0) @(negedge clk);
	endtask

	function automatic logic [143:0] pack9(int e0, int e1, int e2, int e3, int e4,
		int e5, int e6, int e7, int e8);
		logic [15:0] v[9];
		v = '{e0[15:0], e1[15:0], e2[15:0], e3[15:0], e4[15:0],
			e5[15:0], e6[15:0], e7[15:0], e8[15:0]};
		return {v[8], v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
	endfunction

	function automatic int noise(int amp);
		return int'($urandom_range(2 * amp)) - amp;
	endfunction

	// signed permutation matrix with noise of varying amplitude, or full random entries
	function automatic logic [143:0] random_matrix();
		logic [143:0] m;
		int perm[3];
		int sgn, amp, sel, k;
		sel = $urandom_range(99);
		if (sel < 35) begin
			for (int i = 0; i < 9; i++) m[16*i +: 16] = 16'($urandom());
			return m;
		end
		amp  = (sel < 55) ? 8 : ((sel < 80) ? 600 : 6000);
		perm = '{0, 1, 2};
		k = $urandom_range(5);
		if (k[0]) perm = '{1, 0, 2};
		for (int j = 0; j < k / 2; j++) perm = '{perm[1], perm[2], perm[0]};
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				sgn = $urandom_range(1) ? 16384 : -16384;
				m[16*(3*c + r) +: 16] = (perm[c] == r) ? 16'(sgn + noise(amp)) :
					16'(noise(amp));
			end
		end
		return m;
	endfunction

	task automatic test_corner_matrices();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_matrix(pack9(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
		send_matrix(pack9(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
		send_matrix(pack9(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
		send_matrix(pack9(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
		send_matrix(pack9(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
		send_matrix(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_matrix(pack9(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_matrix(pack9(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768));
		send_matrix(pack9(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
			32767));
		send_matrix(pack9(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
			-32768));
		// tiny rotation: sine below the threshold
		send_matrix(pack9(16384, 1, 0, -1, 16384, 0, 0, 0, 16384));
		send_matrix(pack9(16384, 0, 0, 0, 16384, 3, 0, -3, 16384));
		// ties between the w, x and y sums, then the w, y and z sums
		send_matrix(pack9(8192, 5, 7, -3, 8192, 2, 9, -4, -8192));
		send_matrix(pack9(-8192, 1, 2, 3, 8192, 4, 5, 6, 8192));
		send_matrix(pack9(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767,
			32767));
		send_matrix(pack9(11585, 11585, 0, -11585, 11585, 0, 0, 0, 16384));
		wait_drained();
	endtask

	task automatic test_random_phase(int n, int gap_pct, int stall_pct);
		send_idle_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) send_matrix(random_matrix());
	endtask

	task automatic test_receiver_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 500;
		for (int i = 0; i < 150; i++) send_matrix(random_matrix());
	endtask

	task automatic test_drain_pause();
		test_random_phase(60, 10, 10);
		wait_drained();
		test_random_phase(60, 0, 0);
	endtask

	// receiver readiness, changed on the falling edge
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pose_t exp_pose;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pose_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: data %h user %b", m_axis_tdata, m_axis_tuser);
			end else begin
				exp_pose = pose_q.pop_front();
				if (m_axis_tdata !== exp_pose.axes_angle ||
					m_axis_tuser[0] !== exp_pose.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %0d: expected x %h y %h z %h angle %h degen %b, got x %h y %h z %h angle %h degen %b",
							results_seen,
							exp_pose.axes_angle[15:0], exp_pose.axes_angle[31:16],
							exp_pose.axes_angle[47:32], exp_pose.axes_angle[63:48],
							exp_pose.degenerate,
							m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
							m_axis_tdata[63:48], m_axis_tuser[0]);
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		mismatches     = 0;
		results_seen   = 0;
		sent_count     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_matrices();
		test_random_phase(350, 0, 0);
		test_random_phase(350, 81, 0);
		test_random_phase(350, 0, 81);
		test_random_phase(350, 28, 28);
		test_receiver_hold_off();
		test_drain_pause();

		wait_drained();
		repeat (150) @(posedge clk);
		if (pose_q.size() != 0) mismatches++;
		$display("Sent %0d matrices, checked %0d axis-angle results, %0d mismatches.",
			sent_count, results_seen, mismatches);
		$display("Covered corner matrices, all four branches, gaps, stalls and hold-off.");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
